// ----- rtl/core/circular_list_move_engine_top_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef CIRCULAR_LIST_MOVE_ENGINE_TOP_MACROS_SVH
`define CIRCULAR_LIST_MOVE_ENGINE_TOP_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define CLME_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define CLME_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/clme_pkg.sv -----
`default_nettype none

package clme_pkg;

   // Field widths of the request, response and register.
   localparam int FUNC_W       = 2;
   localparam int ITEM_W       = 10;
   localparam int BALL_COUNT_W = 11;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_IDX_W    = CSR_ADDR_W - 2;

   // Ring size after reset and lowest ring size.
   localparam int RESET_COUNT = 1024;
   localparam int MIN_COUNT   = 2;

   // Register index.
   localparam logic [CSR_IDX_W-1:0] REG_BALL_COUNT = '0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_RESTART = 2'd0,
      FUNC_AFTER   = 2'd1,
      FUNC_BEFORE  = 2'd2,
      FUNC_QUERY   = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REBUILD,
      ST_UNLINK,
      ST_READ_B,
      ST_LINK_NEAR,
      ST_LINK_FAR,
      ST_QUERY_OUT
   } state_type;

   // Table read address source.
   typedef enum logic [1:0] {
      RD_REQ,
      RD_ITEM,
      RD_TARGET
   } rd_sel_type;

   // Table write operation.
   typedef enum logic [2:0] {
      WR_NONE,
      WR_REBUILD,
      WR_UNLINK,
      WR_LINK_NEAR,
      WR_LINK_FAR
   } wr_op_type;

   typedef struct packed {
      logic       capture;
      logic       start_rebuild;
      logic       load_rsp;
      rd_sel_type rd_sel;
      wr_op_type  wr_op;
   } cmd_type;

   typedef struct packed {
      logic move_ok;
      logic reb_last;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/clme_ifs.sv -----
`default_nettype none

interface clme_req_if import clme_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ITEM_W-1:0] item;
   logic [ITEM_W-1:0] target;

   modport source (output valid, func, item, target, input ready);
   modport sink (input valid, func, item, target, output ready);
endinterface

interface clme_rsp_if import clme_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ITEM_W-1:0] left_neighbour;
   logic [ITEM_W-1:0] right_neighbour;
   logic              item_valid;

   modport source (output valid, left_neighbour, right_neighbour, item_valid, input ready);
   modport sink (input valid, left_neighbour, right_neighbour, item_valid, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/clme_ram.sv -----
`default_nettype none

module clme_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry (old data on a collision).
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/clme_dp.sv -----
`default_nettype none

module clme_dp import clme_pkg::*; #(
   parameter int MAX_ITEMS = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output status_type                   status,
   input  wire logic [BALL_COUNT_W-1:0] ball_count,
   input  wire logic [FUNC_W-1:0]       req_func,
   input  wire logic [ITEM_W-1:0]       req_item,
   input  wire logic [ITEM_W-1:0]       req_target,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic      [ITEM_W-1:0]       rsp_left_neighbour,
   output logic      [ITEM_W-1:0]       rsp_right_neighbour,
   output logic                         rsp_item_valid
);

   localparam int NODE_W = $clog2(MAX_ITEMS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int CMP_W  = (CNT_W > BALL_COUNT_W) ? CNT_W : BALL_COUNT_W;
   localparam logic [CNT_W-1:0] RESET_LIVE =
      CNT_W'((RESET_COUNT > MAX_ITEMS) ? MAX_ITEMS : RESET_COUNT);

   // Held request.
   logic [NODE_W-1:0] a_ff, a_in;
   logic [NODE_W-1:0] b_ff, b_in;
   logic              after_ff, after_in;
   logic              qvalid_ff, qvalid_in;
   logic [NODE_W-1:0] p_ff, p_in;

   // Ring size and rebuild sweep.
   logic [CNT_W-1:0]  live_count_ff, live_count_in;
   logic [CNT_W-1:0]  reb_count_ff, reb_count_in;
   logic [NODE_W-1:0] reb_idx_ff, reb_idx_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ITEM_W-1:0] rsp_left_ff, rsp_left_in;
   logic [ITEM_W-1:0] rsp_right_ff, rsp_right_in;
   logic              rsp_iv_ff, rsp_iv_in;

   logic [CMP_W-1:0]  bc_wide;
   logic [CNT_W-1:0]  clamped;
   logic              item_ok;
   logic              target_ok;
   logic              reb_last;
   logic [NODE_W-1:0] p_near;

   logic [NODE_W-1:0] rd_addr;
   logic [NODE_W-1:0] succ_rd, pred_rd;
   logic              succ_we, pred_we;
   logic [NODE_W-1:0] succ_wa, succ_wd, pred_wa, pred_wd;

   // Clamp the requested ring size.
   always_comb begin
      bc_wide = CMP_W'(ball_count);
      if (bc_wide < CMP_W'(MIN_COUNT)) begin
         clamped = CNT_W'(MIN_COUNT);
      end else if (bc_wide > CMP_W'(MAX_ITEMS)) begin
         clamped = CNT_W'(MAX_ITEMS);
      end else begin
         clamped = CNT_W'(bc_wide);
      end
   end

   // Range checks on the incoming request.
   assign item_ok   = CMP_W'(req_item) < CMP_W'(live_count_ff);
   assign target_ok = CMP_W'(req_target) < CMP_W'(live_count_ff);
   assign reb_last  = (CNT_W'(reb_idx_ff) + CNT_W'(1)) == reb_count_ff;
   assign p_near    = after_ff ? succ_rd : pred_rd;

   assign status.move_ok  = item_ok && target_ok && (req_item != req_target);
   assign status.reb_last = reb_last;
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   // Select the table read address.
   always_comb begin
      unique case (cmd.rd_sel)
         RD_REQ:    rd_addr = NODE_W'(req_item);
         RD_ITEM:   rd_addr = a_ff;
         RD_TARGET: rd_addr = b_ff;
         default:   rd_addr = a_ff;
      endcase
   end

   // Build the table writes for each step.
   always_comb begin
      succ_we = 1'b0;
      pred_we = 1'b0;
      succ_wa = '0;
      succ_wd = '0;
      pred_wa = '0;
      pred_wd = '0;
      unique case (cmd.wr_op)
         WR_NONE: begin
         end
         WR_REBUILD: begin
            succ_we = 1'b1;
            pred_we = 1'b1;
            succ_wa = reb_idx_ff;
            pred_wa = reb_idx_ff;
            succ_wd = reb_last ? '0 : reb_idx_ff + NODE_W'(1);
            pred_wd = (reb_idx_ff == '0) ? NODE_W'(reb_count_ff - CNT_W'(1))
                                         : reb_idx_ff - NODE_W'(1);
         end
         WR_UNLINK: begin
            // Join the old neighbours of the moved item.
            succ_we = 1'b1;
            pred_we = 1'b1;
            succ_wa = pred_rd;
            succ_wd = succ_rd;
            pred_wa = succ_rd;
            pred_wd = pred_rd;
         end
         WR_LINK_NEAR: begin
            succ_we = 1'b1;
            pred_we = 1'b1;
            if (after_ff) begin
               succ_wa = b_ff;
               succ_wd = a_ff;
               pred_wa = a_ff;
               pred_wd = b_ff;
            end else begin
               pred_wa = b_ff;
               pred_wd = a_ff;
               succ_wa = a_ff;
               succ_wd = b_ff;
            end
         end
         WR_LINK_FAR: begin
            succ_we = 1'b1;
            pred_we = 1'b1;
            if (after_ff) begin
               succ_wa = a_ff;
               succ_wd = p_ff;
               pred_wa = p_ff;
               pred_wd = a_ff;
            end else begin
               pred_wa = a_ff;
               pred_wd = p_ff;
               succ_wa = p_ff;
               succ_wd = a_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Next values of the datapath registers.
   always_comb begin
      a_in          = a_ff;
      b_in          = b_ff;
      after_in      = after_ff;
      qvalid_in     = qvalid_ff;
      p_in          = p_ff;
      live_count_in = live_count_ff;
      reb_count_in  = reb_count_ff;
      reb_idx_in    = reb_idx_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_iv_in     = rsp_iv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.capture) begin
         a_in      = NODE_W'(req_item);
         b_in      = NODE_W'(req_target);
         after_in  = func_type'(req_func) == FUNC_AFTER;
         qvalid_in = item_ok;
      end
      if (cmd.start_rebuild) begin
         reb_count_in  = clamped;
         live_count_in = clamped;
         reb_idx_in    = '0;
      end
      if (cmd.wr_op == WR_REBUILD) begin
         reb_idx_in = reb_last ? '0 : reb_idx_ff + NODE_W'(1);
      end
      if (cmd.wr_op == WR_LINK_NEAR) begin
         p_in = p_near;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_left_in  = qvalid_ff ? ITEM_W'(pred_rd) : '0;
         rsp_right_in = qvalid_ff ? ITEM_W'(succ_rd) : '0;
         rsp_iv_in    = qvalid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         live_count_ff <= RESET_LIVE;
         reb_count_ff  <= RESET_LIVE;
         reb_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         live_count_ff <= live_count_in;
         reb_count_ff  <= reb_count_in;
         reb_idx_ff    <= reb_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      after_ff     <= after_in;
      qvalid_ff    <= qvalid_in;
      p_ff         <= p_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_iv_ff    <= rsp_iv_in;
   end

   clme_ram #(
      .WIDTH(NODE_W),
      .DEPTH(MAX_ITEMS)
   ) u_succ_ram (
      .clock   (clock),
      .wr_en   (succ_we),
      .wr_addr (succ_wa),
      .wr_data (succ_wd),
      .rd_addr (rd_addr),
      .rd_data (succ_rd)
   );

   clme_ram #(
      .WIDTH(NODE_W),
      .DEPTH(MAX_ITEMS)
   ) u_pred_ram (
      .clock   (clock),
      .wr_en   (pred_we),
      .wr_addr (pred_wa),
      .wr_data (pred_wd),
      .rd_addr (rd_addr),
      .rd_data (pred_rd)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_neighbour  = rsp_left_ff;
   assign rsp_right_neighbour = rsp_right_ff;
   assign rsp_item_valid      = rsp_iv_ff;

endmodule

`default_nettype wire

// ----- rtl/core/clme_ctrl.sv -----
`default_nettype none

module clme_ctrl import clme_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [FUNC_W-1:0] req_func,
   output logic                   req_ready,
   output cmd_type                cmd,
   input  wire status_type        status
);

   state_type state_ff, state_in;

   // Hold the state; reset starts the ring rebuild.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_REBUILD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence the table accesses of each request.
   always_comb begin
      state_in          = state_ff;
      req_ready         = 1'b0;
      cmd.capture       = 1'b0;
      cmd.start_rebuild = 1'b0;
      cmd.load_rsp      = 1'b0;
      cmd.rd_sel        = RD_TARGET;
      cmd.wr_op         = WR_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.rd_sel  = RD_REQ;
            cmd.capture = req_valid;
            if (req_valid) begin
               unique case (func_type'(req_func))
                  FUNC_RESTART: begin
                     cmd.start_rebuild = 1'b1;
                     state_in          = ST_REBUILD;
                  end
                  FUNC_QUERY: begin
                     state_in = ST_QUERY_OUT;
                  end
                  FUNC_AFTER, FUNC_BEFORE: begin
                     // Drop moves that are out of range or onto the item itself.
                     state_in = status.move_ok ? ST_UNLINK : ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_REBUILD: begin
            cmd.wr_op = WR_REBUILD;
            if (status.reb_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_UNLINK: begin
            cmd.wr_op = WR_UNLINK;
            state_in  = ST_READ_B;
         end
         ST_READ_B: begin
            state_in = ST_LINK_NEAR;
         end
         ST_LINK_NEAR: begin
            cmd.wr_op = WR_LINK_NEAR;
            state_in  = ST_LINK_FAR;
         end
         ST_LINK_FAR: begin
            cmd.wr_op = WR_LINK_FAR;
            state_in  = ST_IDLE;
         end
         ST_QUERY_OUT: begin
            // Keep the read address so the table data stays put while stalled.
            cmd.rd_sel = RD_ITEM;
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/circular_list_move_engine_top.sv -----
// Query: response loaded once the output is free; no new request is taken before then.
// Move: dependent read/unlink/read/link/link steps on the single-port-read predecessor
//   and successor RAMs, ready again after the far link; rejected moves leave the block idle.
// Restart: a rebuild over clamp(ball_count) entries, one ring entry per cycle.
// Reset: synchronous, active high; runs a rebuild over min(1024, MAX_ITEMS) entries,
//   with req ready low for those cycles. Register writes are taken at any time.
`default_nettype none

module circular_list_move_engine_top import clme_pkg::*; #(
   parameter int MAX_ITEMS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   clme_req_if.sink                   req_chan,
   clme_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic [BALL_COUNT_W-1:0] ball_count_ff, ball_count_in;
   logic [CSR_IDX_W-1:0]    csr_idx;
   logic                    csr_write;
   cmd_type                 cmd;
   status_type              status;
   logic                    rsp_valid;
   logic [ITEM_W-1:0]       rsp_left;
   logic [ITEM_W-1:0]       rsp_right;
   logic                    rsp_item_valid;

   // Decode the register port.
   assign csr_idx   = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (csr_idx == REG_BALL_COUNT) ? CSR_DATA_W'(ball_count_ff) : '0;

   always_comb begin
      ball_count_in = ball_count_ff;
      if (csr_write && (csr_idx == REG_BALL_COUNT)) begin
         ball_count_in = pwdata[BALL_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ball_count_ff <= BALL_COUNT_W'(RESET_COUNT);
      end else begin
         ball_count_ff <= ball_count_in;
      end
   end

   clme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   clme_dp #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .ball_count          (ball_count_ff),
      .req_func            (req_chan.func),
      .req_item            (req_chan.item),
      .req_target          (req_chan.target),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_valid),
      .rsp_left_neighbour  (rsp_left),
      .rsp_right_neighbour (rsp_right),
      .rsp_item_valid      (rsp_item_valid)
   );

   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.left_neighbour  = rsp_left;
   assign rsp_chan.right_neighbour = rsp_right;
   assign rsp_chan.item_valid      = rsp_item_valid;

endmodule

`default_nettype wire

// ----- rtl/core/clme_checker.sv -----
`default_nettype none
`include "circular_list_move_engine_top_macros.svh"

module clme_checker import clme_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [FUNC_W-1:0] req_func,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [ITEM_W-1:0] rsp_left,
   input wire logic [ITEM_W-1:0] rsp_right,
   input wire logic              rsp_item_valid
);

   logic req_fire;
   logic req_long;

   assign req_fire = req_valid && req_ready;
   assign req_long = (req_func == FUNC_RESTART) || (req_func == FUNC_QUERY);

   // A stalled response keeps its contents.
   `CLME_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left) && $stable(rsp_right) && $stable(rsp_item_valid), "response changed while stalled")

   // Reset starts a rebuild, so no request is taken right after it.
   `CLME_ASSERT_ALWAYS(a_busy_after_reset, clock, reset |=> !req_ready, "ready high right after reset")

   // Restart and query keep the block busy for the next cycle.
   `CLME_ASSERT(a_busy_after_long, clock, reset, req_fire && req_long |=> !req_ready, "ready high right after restart or query")

   // An out-of-range query reports zero neighbours.
   `CLME_ASSERT(a_invalid_zero, clock, reset, rsp_valid && !rsp_item_valid |-> rsp_left == '0 && rsp_right == '0, "invalid query has nonzero neighbours")

endmodule

bind circular_list_move_engine_top clme_checker u_clme_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_func       (req_chan.func),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_left       (rsp_chan.left_neighbour),
   .rsp_right      (rsp_chan.right_neighbour),
   .rsp_item_valid (rsp_chan.item_valid)
);

`default_nettype wire

// ----- dv/circular_list_move_engine_top_tb.sv -----
`timescale 1ns / 1ps

module circular_list_move_engine_top_tb;
   import clme_pkg::*;

   localparam int MAX_ITEMS      = 1024;
   localparam int CLOCK_HALF     = 5;
   localparam int SETTLE_CYCLES  = MAX_ITEMS + 40;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int MAX_REPORTS    = 10;

   localparam logic [CSR_ADDR_W-1:0] ADDR_BALL_COUNT = {REG_BALL_COUNT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED   = {REG_BALL_COUNT + 1'b1, 2'b00};

   typedef struct packed {
      logic [ITEM_W-1:0] left_neighbour;
      logic [ITEM_W-1:0] right_neighbour;
      logic              item_valid;
   } neighbours_type;

   // Ring predictor and store of expected query responses.
   class neighbour_scoreboard;
      bit [ITEM_W-1:0] succ_tab [MAX_ITEMS];
      bit [ITEM_W-1:0] pred_tab [MAX_ITEMS];
      int unsigned     ball_count;
      int unsigned     live_count;
      int unsigned     errors;
      neighbours_type  expected_q [$];

      function new();
         ball_count = RESET_COUNT;
         errors     = 0;
         rebuild_ring();
      endfunction

      function void set_ball_count(bit [BALL_COUNT_W-1:0] value);
         ball_count = value;
      endfunction

      // Clamp the count and lay the ring out in index order.
      function void rebuild_ring();
         int unsigned cnt;
         cnt = ball_count;
         if (cnt < MIN_COUNT) cnt = MIN_COUNT;
         if (cnt > MAX_ITEMS) cnt = MAX_ITEMS;
         for (int unsigned i = 0; i < cnt; i++) begin
            succ_tab[i] = (i + 1 == cnt) ? '0 : ITEM_W'(i + 1);
            pred_tab[i] = (i == 0) ? ITEM_W'(cnt - 1) : ITEM_W'(i - 1);
         end
         live_count = cnt;
      endfunction

      // Unlink item a and relink it beside b.
      function void relocate(bit [ITEM_W-1:0] a, bit [ITEM_W-1:0] b, bit after);
         bit [ITEM_W-1:0] p1, p2, p;
         p1 = pred_tab[a];
         p2 = succ_tab[a];
         succ_tab[p1] = p2;
         pred_tab[p2] = p1;
         if (after) begin
            p = succ_tab[b];
            succ_tab[b] = a;
            pred_tab[a] = b;
            succ_tab[a] = p;
            pred_tab[p] = a;
         end else begin
            p = pred_tab[b];
            pred_tab[b] = a;
            succ_tab[a] = b;
            pred_tab[a] = p;
            succ_tab[p] = a;
         end
      endfunction

      function void take_request(func_type f, bit [ITEM_W-1:0] it, bit [ITEM_W-1:0] tg);
         neighbours_type exp_n;
         case (f)
            FUNC_RESTART: begin
               rebuild_ring();
            end
            FUNC_QUERY: begin
               if (it < live_count) begin
                  exp_n.left_neighbour  = pred_tab[it];
                  exp_n.right_neighbour = succ_tab[it];
                  exp_n.item_valid      = 1'b1;
               end else begin
                  exp_n = '0;
               end
               expected_q.push_back(exp_n);
            end
            default: begin
               if (it != tg && it < live_count && tg < live_count)
                  relocate(it, tg, f == FUNC_AFTER);
            end
         endcase
      endfunction

      function void check_neighbours(neighbours_type got);
         neighbours_type exp_n;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("ERROR: unexpected response left=%0d right=%0d valid=%0b",
                        got.left_neighbour, got.right_neighbour, got.item_valid);
            return;
         end
         exp_n = expected_q.pop_front();
         if (got !== exp_n) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display({"ERROR: response exp left=%0d right=%0d valid=%0b,",
                         " got left=%0d right=%0d valid=%0b"},
                        exp_n.left_neighbour, exp_n.right_neighbour, exp_n.item_valid,
                        got.left_neighbour, got.right_neighbour, got.item_valid);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   clme_req_if req_chan ();
   clme_rsp_if rsp_chan ();

   neighbour_scoreboard sb = new();

   int burst_left;
   int idle_cycles;
   int stall_mode;
   int stall_count;

   circular_list_move_engine_top #(
      .MAX_ITEMS(MAX_ITEMS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Free-running clock.
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Observe requests, responses and register writes.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.take_request(func_type'(req_chan.func), req_chan.item, req_chan.target);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_neighbours({rsp_chan.left_neighbour, rsp_chan.right_neighbour,
                                 rsp_chan.item_valid});
         if (psel && penable && pwrite && pready &&
             paddr[CSR_ADDR_W-1:2] == REG_BALL_COUNT)
            sb.set_ball_count(pwdata[BALL_COUNT_W-1:0]);
      end
   end

   // Count cycles without progress; stop a hung run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response backpressure: pick a new stall pattern each time the stall counter runs out.
   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_count = 64;
      end
      stall_count--;
      case (stall_mode)
         0:       rsp_chan.ready <= 1'b1;
         1:       rsp_chan.ready <= $urandom_range(0, 1);
         2:       rsp_chan.ready <= (stall_count % 8 == 0);
         default: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Drive one request in bursts with random gaps; hold until taken.
   task automatic send_request(func_type f, int it, int tg);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 3) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid  <= 1'b1;
      req_chan.func   <= f;
      req_chan.item   <= ITEM_W'(it);
      req_chan.target <= ITEM_W'(tg);
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drain outstanding work so the block is idle.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Two-phase register write; the bus is left idle after it.
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_ball_count(int value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      data[BALL_COUNT_W-1:0] = BALL_COUNT_W'(value);
      csr_write(ADDR_BALL_COUNT, data);
   endtask

   // Random request: mostly in-range moves and queries, some noise.
   task automatic send_random_request();
      int       sel;
      int       it, tg;
      func_type f;
      sel = $urandom_range(0, 99);
      if (sel < 4)       f = FUNC_RESTART;
      else if (sel < 60) f = ($urandom_range(0, 1) != 0) ? FUNC_AFTER : FUNC_BEFORE;
      else               f = FUNC_QUERY;
      if ($urandom_range(0, 99) < 85) begin
         it = $urandom_range(0, sb.live_count - 1);
         tg = $urandom_range(0, sb.live_count - 1);
      end else begin
         it = $urandom_range(0, (1 << ITEM_W) - 1);
         tg = $urandom_range(0, (1 << ITEM_W) - 1);
      end
      if ($urandom_range(0, 19) == 0) tg = it;
      send_request(f, it, tg);
   endtask

   initial begin
      int sent;
      int phase_len;
      int pick;
      int count_sel;

      clock           = 1'b0;
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_chan.valid  = 1'b0;
      req_chan.func   = FUNC_RESTART;
      req_chan.item   = '0;
      req_chan.target = '0;
      rsp_chan.ready  = 1'b0;
      burst_left      = 0;
      idle_cycles     = 0;
      stall_mode      = 0;
      stall_count     = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Ring after reset: ends wrap, same-item move, adjacent moves.
      send_request(FUNC_QUERY, 0, 0);
      send_request(FUNC_QUERY, 1023, 0);
      send_request(FUNC_AFTER, 5, 5);
      send_request(FUNC_QUERY, 5, 0);
      send_request(FUNC_AFTER, 0, 1023);
      send_request(FUNC_BEFORE, 1023, 0);
      send_request(FUNC_AFTER, 3, 700);
      send_request(FUNC_QUERY, 3, 0);
      send_request(FUNC_QUERY, 700, 0);
      send_request(FUNC_QUERY, 2, 0);
      send_request(FUNC_QUERY, 1023, 0);

      // Count below the minimum; unmapped register write is dropped.
      settle();
      write_ball_count(0);
      csr_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
      send_request(FUNC_RESTART, 0, 0);
      send_request(FUNC_QUERY, 0, 0);
      send_request(FUNC_QUERY, 2, 0);
      send_request(FUNC_QUERY, 1023, 0);
      send_request(FUNC_AFTER, 0, 1);
      send_request(FUNC_BEFORE, 1, 5);
      send_request(FUNC_QUERY, 1, 0);

      // Count above the maximum; the new count takes effect only on restart.
      settle();
      write_ball_count(2047);
      send_request(FUNC_QUERY, 500, 0);
      send_request(FUNC_RESTART, 0, 0);
      send_request(FUNC_QUERY, 1023, 0);
      send_request(FUNC_BEFORE, 1023, 512);
      send_request(FUNC_QUERY, 512, 0);

      // Random phases, each with its own ring size.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         count_sel = $urandom_range(0, 99);
         if (count_sel < 60) begin
            pick = $urandom_range(2, 16);
         end else if (count_sel < 85) begin
            pick = $urandom_range(17, 200);
         end else begin
            case ($urandom_range(0, 6))
               0:       pick = 0;
               1:       pick = 1;
               2:       pick = 2;
               3:       pick = 1023;
               4:       pick = 1024;
               5:       pick = 1025;
               default: pick = 2047;
            endcase
         end
         write_ball_count(pick);
         if ($urandom_range(0, 7) == 0)
            csr_write(ADDR_UNMAPPED, $urandom);
         if ($urandom_range(0, 99) < 85)
            send_request(FUNC_RESTART, $urandom_range(0, 1023), $urandom_range(0, 1023));
         phase_len = $urandom_range(40, 150);
         repeat (phase_len) send_random_request();
         sent += phase_len;
      end
      req_chan.valid <= 1'b0;

      // Drain and finish.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- circular_list_move_engine_top.f -----
+incdir+rtl/core
rtl/core/clme_pkg.sv
rtl/core/clme_ifs.sv
rtl/core/clme_ram.sv
rtl/core/clme_dp.sv
rtl/core/clme_ctrl.sv
rtl/core/circular_list_move_engine_top.sv
rtl/core/clme_checker.sv
dv/circular_list_move_engine_top_tb.sv
